>>> rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off during reset
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("implication check failed");

// next-cycle implication, also checked while reset is high
`define ASSERT_NEXT(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/lpip_pkg.sv
`timescale 1ns / 1ps

package lpip_pkg;

   typedef logic [2:0] kind_type;

   localparam kind_type K_LENGTH    = 3'd0;
   localparam kind_type K_CONTENT   = 3'd1;
   localparam kind_type K_ELEM_END  = 3'd2;
   localparam kind_type K_INSTR_END = 3'd3;
   localparam kind_type K_ERROR     = 3'd4;
   localparam kind_type K_IGNORED   = 3'd5;

   localparam logic [1:0] PH_LENGTH   = 2'd0;
   localparam logic [1:0] PH_CONTENT  = 2'd1;
   localparam logic [1:0] PH_COMPLETE = 2'd2;
   localparam logic [1:0] PH_ERROR    = 2'd3;

   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_PERIOD    = 8'h2E;
   localparam logic [7:0] CH_SEMICOLON = 8'h3B;
   localparam logic [7:0] CH_COMMA     = 8'h2C;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ELEMENT_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ELEMENTS       = 2'd1;

   localparam logic [15:0] MAX_ELEMENT_LENGTH_RESET = 16'd8192;
   localparam logic [7:0]  MAX_ELEMENTS_RESET       = 8'd128;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte_out;
      logic        char_start;
      logic [6:0]  element_index;
      logic [15:0] declared_length;
      logic [6:0]  arg_count;
   } result_type;

   // continuation bytes that follow a lead byte; odd lead bytes count as one byte
   function automatic logic [1:0] utf8_follow(input logic [7:0] b);
      logic [1:0] n;
      n = 2'd0;
      if (b[7:5] == 3'b110) begin
         n = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         n = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         n = 2'd3;
      end
      return n;
   endfunction

endpackage

>>> rtl/length_prefixed_instruction_parser.sv
`timescale 1ns / 1ps
// Byte-wide parser for length-prefixed instructions ("5.hello,3.abc;").
// req_ channel: one stream byte per transaction (req_valid / req_stall).
// rsp_ channel: one classified byte per input byte, in order: kind, the byte
//    itself, character start flag, element index, declared length and, on an
//    instruction end, the argument count.
// csr_ channel: register 0 max_element_length, register 1 max_elements;
//    csr_ready is always high, write only while the parser is idle.
// Each result is registered, in the result register or in the skid register.
// Throughput: one byte per cycle while req_stall is low; the phase and counter
//    update is combinational logic ahead of the result register.
// When the receiver stalls, the result register holds and a one-entry skid
//    register takes one more result; req_stall rises only when the skid
//    register is full.
// Any protocol fault gives an error result for that byte and every later
//    byte until reset.
// Reset (synchronous, active high) returns the parser to the length phase of
//    a new instruction, clears both output valid flags and restores the
//    configuration defaults 8192 and 128. No clearing pass is needed.
module length_prefixed_instruction_parser #(
   parameter int ELEMENT_LIMIT = 128,
   parameter int LENGTH_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lpip_pkg::kind_type    rsp_kind,
   output logic [7:0]            rsp_data_byte_out,
   output logic                  rsp_char_start,
   output logic [6:0]            rsp_element_index,
   output logic [15:0]           rsp_declared_length,
   output logic [6:0]            rsp_arg_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  lpip_pkg::csr_index_type csr_index,
   input  lpip_pkg::csr_data_type  csr_data
);
   import lpip_pkg::*;

   localparam int CNT_W = (ELEMENT_LIMIT >= 255) ? 8 : $clog2(ELEMENT_LIMIT + 1);
   localparam int MW    = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
   localparam int CW    = MW + 4;
   localparam int VW    = LENGTH_BITS + 4;
   localparam logic [MW-1:0] LEN_CAP = MW'((64'd1 << LENGTH_BITS) - 64'd1);

   logic [15:0]            max_element_length_ff;
   logic [7:0]             max_elements_ff;

   logic [1:0]             phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] length_count_ff, length_count_in;
   logic [LENGTH_BITS-1:0] kept_ff, kept_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [1:0]             cont_ff, cont_in;

   logic [1:0]             phase_cur;
   logic [LENGTH_BITS-1:0] length_count_cur, kept_cur;
   logic [CNT_W-1:0]       count_cur;
   logic [1:0]             cont_cur;

   logic [MW-1:0]          len_limit;
   logic [8:0]             elem_cap;
   logic [VW-1:0]          acc;
   logic [7:0]             idx_wide;
   logic [31:0]            decl_wide;

   result_type             res;
   result_type             out_ff;
   result_type             skid_ff;
   logic                   out_valid_ff;
   logic                   skid_valid_ff;

   logic                   req_take;
   logic                   rsp_take;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_element_length_ff <= MAX_ELEMENT_LENGTH_RESET;
         max_elements_ff       <= MAX_ELEMENTS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_ELEMENT_LENGTH: max_element_length_ff <= csr_data[15:0];
            CSR_MAX_ELEMENTS:       max_elements_ff       <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      len_limit = (MW'(max_element_length_ff) < LEN_CAP) ? MW'(max_element_length_ff)
                                                          : LEN_CAP;
      elem_cap  = (9'(max_elements_ff) < 9'(ELEMENT_LIMIT)) ? 9'(max_elements_ff)
                                                             : 9'(ELEMENT_LIMIT);
   end

   always_comb begin
      // an instruction end leaves the counters to be cleared by the next byte
      if (phase_ff == PH_COMPLETE) begin
         phase_cur        = PH_LENGTH;
         length_count_cur = '0;
         kept_cur         = '0;
         count_cur        = '0;
         cont_cur         = '0;
      end else begin
         phase_cur        = phase_ff;
         length_count_cur = length_count_ff;
         kept_cur         = kept_ff;
         count_cur        = count_ff;
         cont_cur         = cont_ff;
      end

      phase_in        = phase_cur;
      length_count_in = length_count_cur;
      kept_in         = kept_cur;
      count_in        = count_cur;
      cont_in         = cont_cur;

      acc = (VW'(length_count_cur) << 3) + (VW'(length_count_cur) << 1)
          + VW'(req_data_byte - CH_ZERO);

      res               = '0;
      res.kind          = K_ERROR;
      res.data_byte_out = req_data_byte;
      idx_wide          = '0;
      decl_wide         = '0;

      case (phase_cur)
         PH_LENGTH: begin
            if (9'(count_cur) >= elem_cap) begin
               phase_in = PH_ERROR;
            end else if (req_data_byte inside {[CH_ZERO:CH_NINE]}) begin
               if (CW'(acc) > CW'(len_limit)) begin
                  phase_in = PH_ERROR;
               end else begin
                  length_count_in = acc[LENGTH_BITS-1:0];
                  res.kind        = K_LENGTH;
                  idx_wide        = 8'(count_cur);
                  decl_wide       = 32'(acc);
               end
            end else if (req_data_byte == CH_PERIOD) begin
               kept_in   = length_count_cur;
               idx_wide  = 8'(count_cur);
               count_in  = count_cur + CNT_W'(1);
               cont_in   = '0;
               phase_in  = PH_CONTENT;
               res.kind  = K_LENGTH;
               decl_wide = 32'(length_count_cur);
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_CONTENT: begin
            idx_wide  = 8'(count_cur) - 8'd1;
            decl_wide = 32'(kept_cur);
            if (cont_cur != 2'd0) begin
               cont_in  = cont_cur - 2'd1;
               res.kind = K_CONTENT;
            end else if (length_count_cur == '0) begin
               if (req_data_byte == CH_SEMICOLON) begin
                  phase_in      = PH_COMPLETE;
                  res.kind      = K_INSTR_END;
                  res.arg_count = idx_wide[6:0];
               end else if (req_data_byte == CH_COMMA) begin
                  phase_in        = PH_LENGTH;
                  length_count_in = '0;
                  res.kind        = K_ELEM_END;
               end else begin
                  phase_in = PH_ERROR;
               end
            end else begin
               cont_in         = utf8_follow(req_data_byte);
               length_count_in = length_count_cur - LENGTH_BITS'(1);
               res.kind        = K_CONTENT;
               res.char_start  = 1'b1;
            end
         end
         default: ;
      endcase

      res.element_index   = idx_wide[6:0];
      res.declared_length = decl_wide[15:0];

      if (phase_in == PH_ERROR) begin
         res.kind            = K_ERROR;
         res.char_start      = 1'b0;
         res.element_index   = '0;
         res.declared_length = '0;
         res.arg_count       = '0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LENGTH;
         length_count_ff <= '0;
         kept_ff         <= '0;
         count_ff        <= '0;
         cont_ff         <= '0;
      end else if (req_take) begin
         phase_ff        <= phase_in;
         length_count_ff <= length_count_in;
         kept_ff         <= kept_in;
         count_ff        <= count_in;
         cont_ff         <= cont_in;
      end
   end

   // result register with one-entry skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_take) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (req_take) begin
            if (out_valid_ff && !rsp_take) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_ff <= skid_ff;
         end
      end else if (req_take) begin
         if (out_valid_ff && !rsp_take) begin
            skid_ff <= res;
         end else begin
            out_ff <= res;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_ff.kind;
   assign rsp_data_byte_out   = out_ff.data_byte_out;
   assign rsp_char_start      = out_ff.char_start;
   assign rsp_element_index   = out_ff.element_index;
   assign rsp_declared_length = out_ff.declared_length;
   assign rsp_arg_count       = out_ff.arg_count;

endmodule

>>> rtl/lpip_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpip_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input lpip_pkg::kind_type rsp_kind,
   input logic               rsp_char_start,
   input logic [6:0]         rsp_element_index,
   input logic [15:0]        rsp_declared_length,
   input logic [6:0]         rsp_arg_count
);
   import lpip_pkg::*;

   logic err_seen_ff, err_seen_in;

   // once an error transaction has gone out, only error results may follow
   assign err_seen_in = err_seen_ff || (rsp_valid && !rsp_stall && rsp_kind == K_ERROR);

   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else begin
         err_seen_ff <= err_seen_in;
      end
   end

   `ASSERT_IMPLY(a_error_sticky, clock, reset, rsp_valid && err_seen_ff, rsp_kind == K_ERROR)
   `ASSERT_IMPLY(a_error_fields_clear, clock, reset, rsp_valid && rsp_kind == K_ERROR,
                 !rsp_char_start && rsp_element_index == 7'd0 && rsp_declared_length == 16'd0)
   `ASSERT_IMPLY(a_arg_count_only_at_end, clock, reset, rsp_valid && rsp_kind != K_INSTR_END,
                 rsp_arg_count == 7'd0)
   `ASSERT_IMPLY(a_stall_needs_pending, clock, reset, req_stall, rsp_valid)
   `ASSERT_NEXT(a_reset_empties, clock, reset, !rsp_valid && !req_stall)

endmodule

bind length_prefixed_instruction_parser lpip_checker u_lpip_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_kind            (rsp_kind),
   .rsp_char_start      (rsp_char_start),
   .rsp_element_index   (rsp_element_index),
   .rsp_declared_length (rsp_declared_length),
   .rsp_arg_count       (rsp_arg_count)
);

>>> verif/length_prefixed_instruction_parser_tb.sv
`timescale 1ns / 1ps

module length_prefixed_instruction_parser_tb;

   import lpip_pkg::*;

   localparam int ELEMENT_CAP    = 128;
   localparam int LENGTH_W       = 16;
   localparam int LENGTH_CEIL    = (1 << LENGTH_W) - 1;
   localparam int ITEMS          = 1250;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [7:0] data;
      bit         typed;
      result_type res;
   } script_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_data_byte = 8'h00;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   kind_type      rsp_kind;
   logic [7:0]    rsp_data_byte_out;
   logic          rsp_char_start;
   logic [6:0]    rsp_element_index;
   logic [15:0]   rsp_declared_length;
   logic [6:0]    rsp_arg_count;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_MAX_ELEMENT_LENGTH;
   csr_data_type  csr_data = '0;

   // side band that travels with each byte: a hand-written expectation
   bit            drv_typed = 1'b0;
   result_type    drv_typed_res = '0;

   // parser state as the checker sees it
   logic [1:0]    parse_ph;
   int unsigned   chars_left;
   logic [15:0]   elem_len;
   logic [7:0]    elem_total;
   logic [1:0]    tail_bytes;
   logic [15:0]   pred_max_len;
   logic [7:0]    pred_max_el;

   // limits as the stimulus side knows them
   logic [15:0]   stim_max_len = MAX_ELEMENT_LENGTH_RESET;
   logic [7:0]    stim_max_el = MAX_ELEMENTS_RESET;

   result_type    byte_classes [$];
   result_type    seen_class;
   result_type    want_class;
   result_type    next_class;
   int            bytes_taken = 0;
   int            classes_seen = 0;
   int            bad_classes = 0;
   int            quiet_cycles = 0;
   bit            progress;
   int            send_idle_pct = 34;
   int            recv_idle_pct = 83;

   script_row_type opening_rows [0:20];

   always #1 clock = ~clock;

   length_prefixed_instruction_parser #(
      .ELEMENT_LIMIT(ELEMENT_CAP),
      .LENGTH_BITS  (LENGTH_W)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte_out  (rsp_data_byte_out),
      .rsp_char_start     (rsp_char_start),
      .rsp_element_index  (rsp_element_index),
      .rsp_declared_length(rsp_declared_length),
      .rsp_arg_count      (rsp_arg_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // continuation bytes announced by a lead byte
   function automatic logic [1:0] lead_follow(input logic [7:0] b);
      if ((b | 8'h1F) == 8'hDF) return 2'd1;
      if ((b | 8'h0F) == 8'hEF) return 2'd2;
      if ((b | 8'h07) == 8'hF7) return 2'd3;
      return 2'd0;
   endfunction

   function automatic result_type classify_byte(input logic [7:0] b);
      result_type  r;
      int unsigned acc;
      int unsigned len_cap;
      int unsigned el_cap;
      logic [7:0]  last;
      r = '0;
      r.kind = K_ERROR;
      r.data_byte_out = b;
      len_cap = (pred_max_len < LENGTH_CEIL) ? pred_max_len : LENGTH_CEIL;
      el_cap = (pred_max_el < ELEMENT_CAP) ? pred_max_el : ELEMENT_CAP;
      if (parse_ph == PH_COMPLETE) begin
         parse_ph = PH_LENGTH;
         chars_left = 0;
         elem_len = '0;
         elem_total = '0;
         tail_bytes = '0;
      end
      if (parse_ph == PH_LENGTH) begin
         if (elem_total >= el_cap) begin
            parse_ph = PH_ERROR;
         end else if (b >= CH_ZERO && b <= CH_NINE) begin
            acc = chars_left * 10 + (b - CH_ZERO);
            if (acc > len_cap) begin
               parse_ph = PH_ERROR;
            end else begin
               chars_left = acc;
               r.kind = K_LENGTH;
               r.element_index = elem_total[6:0];
               r.declared_length = chars_left[15:0];
            end
         end else if (b == CH_PERIOD) begin
            elem_len = chars_left[15:0];
            r.element_index = elem_total[6:0];
            elem_total = elem_total + 8'd1;
            tail_bytes = '0;
            parse_ph = PH_CONTENT;
            r.kind = K_LENGTH;
            r.declared_length = elem_len;
         end else begin
            parse_ph = PH_ERROR;
         end
      end else if (parse_ph == PH_CONTENT) begin
         last = elem_total - 8'd1;
         r.element_index = last[6:0];
         r.declared_length = elem_len;
         if (tail_bytes != 0) begin
            tail_bytes = tail_bytes - 2'd1;
            r.kind = K_CONTENT;
         end else if (chars_left == 0) begin
            if (b == CH_SEMICOLON) begin
               parse_ph = PH_COMPLETE;
               r.kind = K_INSTR_END;
               r.arg_count = last[6:0];
            end else if (b == CH_COMMA) begin
               parse_ph = PH_LENGTH;
               chars_left = 0;
               r.kind = K_ELEM_END;
            end else begin
               parse_ph = PH_ERROR;
            end
         end else begin
            tail_bytes = lead_follow(b);
            chars_left = chars_left - 1;
            r.kind = K_CONTENT;
            r.char_start = 1'b1;
         end
      end
      if (parse_ph == PH_ERROR) begin
         r = '0;
         r.kind = K_ERROR;
         r.data_byte_out = b;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // checks results, predicts each accepted byte and tracks register writes
   always @(posedge clock) begin
      if (reset) begin
         parse_ph = PH_LENGTH;
         chars_left = 0;
         elem_len = '0;
         elem_total = '0;
         tail_bytes = '0;
         pred_max_len = MAX_ELEMENT_LENGTH_RESET;
         pred_max_el = MAX_ELEMENTS_RESET;
         quiet_cycles = 0;
      end else begin
         progress = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            seen_class = '{rsp_kind, rsp_data_byte_out, rsp_char_start, rsp_element_index,
                           rsp_declared_length, rsp_arg_count};
            classes_seen <= classes_seen + 1;
            if (byte_classes.size() == 0) begin
               if (bad_classes < 10) begin
                  $display("unexpected result: byte %02h kind %0d", seen_class.data_byte_out,
                           seen_class.kind);
               end
               bad_classes++;
            end else begin
               want_class = byte_classes.pop_front();
               if (seen_class.kind !== want_class.kind ||
                   seen_class.data_byte_out !== want_class.data_byte_out ||
                   seen_class.char_start !== want_class.char_start ||
                   seen_class.element_index !== want_class.element_index ||
                   seen_class.declared_length !== want_class.declared_length ||
                   seen_class.arg_count !== want_class.arg_count) begin
                  if (bad_classes < 10) begin
                     $display("mismatch: exp kind %0d byte %02h start %0d idx %0d len %0d argc %0d",
                              want_class.kind, want_class.data_byte_out, want_class.char_start,
                              want_class.element_index, want_class.declared_length,
                              want_class.arg_count);
                     $display("          got kind %0d byte %02h start %0d idx %0d len %0d argc %0d",
                              seen_class.kind, seen_class.data_byte_out, seen_class.char_start,
                              seen_class.element_index, seen_class.declared_length,
                              seen_class.arg_count);
                  end
                  bad_classes++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            progress = 1'b1;
            next_class = classify_byte(req_data_byte);
            byte_classes.push_back(drv_typed ? drv_typed_res : next_class);
         end
         if (csr_valid && csr_ready) begin
            progress = 1'b1;
            if (csr_index == CSR_MAX_ELEMENT_LENGTH) begin
               pred_max_len = csr_data;
            end else if (csr_index == CSR_MAX_ELEMENTS) begin
               pred_max_el = csr_data[7:0];
            end
         end
         if (progress) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit typed, input result_type tres);
      if (bytes_taken >= 2 * ITEMS / 3) begin
         send_idle_pct = 0;
         recv_idle_pct <= 0;
      end else if (bytes_taken >= ITEMS / 3) begin
         send_idle_pct = 83;
         recv_idle_pct <= 34;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      drv_typed <= typed;
      drv_typed_res <= tres;
      do @(posedge clock); while (req_stall);
      bytes_taken++;
   endtask

   task automatic send_plain(input logic [7:0] b);
      send_byte(b, 1'b0, '0);
   endtask

   task automatic send_fault_byte(input logic [7:0] b);
      send_byte(b, 1'b1, '{K_ERROR, b, 1'b0, 7'd0, 16'd0, 7'd0});
   endtask

   // the sender goes quiet so the last transaction is not offered again
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (classes_seen < bytes_taken) @(posedge clock);
   endtask

   task automatic set_limits(input logic [15:0] len, input logic [7:0] el);
      stim_max_len = len;
      stim_max_el = el;
      csr_valid <= 1'b1;
      csr_index <= CSR_MAX_ELEMENT_LENGTH;
      csr_data <= len;
      do @(posedge clock); while (!csr_ready);
      // upper byte is not part of the register
      csr_index <= CSR_MAX_ELEMENTS;
      csr_data <= {8'($urandom_range(255)), el};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic int unsigned stim_cap();
      return (stim_max_el < ELEMENT_CAP) ? stim_max_el : ELEMENT_CAP;
   endfunction

   function automatic int unsigned pick_length(input bit tiny);
      int unsigned top;
      int unsigned r;
      top = tiny ? 1 : 12;
      r = $urandom_range(15);
      if (!tiny && r == 0) top = 300;
      if (top > stim_max_len) top = stim_max_len;
      if (!tiny && r == 1) return top;
      return $urandom_range(top);
   endfunction

   task automatic send_char();
      int unsigned pick;
      int unsigned follow;
      logic [7:0]  lead;
      pick = $urandom_range(9);
      follow = 0;
      if (pick <= 4) begin
         lead = 8'($urandom_range(8'h7F));
      end else if (pick == 5) begin
         lead = 8'hC0 | 8'($urandom_range(31));
         follow = 1;
      end else if (pick == 6) begin
         lead = 8'hE0 | 8'($urandom_range(15));
         follow = 2;
      end else if (pick == 7) begin
         lead = 8'hF0 | 8'($urandom_range(7));
         follow = 3;
      end else if (pick == 8) begin
         lead = 8'h80 | 8'($urandom_range(63));
      end else begin
         lead = 8'hF8 | 8'($urandom_range(7));
      end
      send_plain(lead);
      // continuation bytes are never looked at, so any value will do
      repeat (follow) send_plain(8'($urandom_range(255)));
   endtask

   task automatic send_length(input int unsigned n);
      string       digits;
      int unsigned pad;
      int          i;
      digits = $sformatf("%0d", n);
      pad = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
      repeat (pad) send_plain(CH_ZERO);
      // a bare period also declares zero characters
      if (!(n == 0 && $urandom_range(3) == 0)) begin
         for (i = 0; i < digits.len(); i++) send_plain(digits[i]);
      end
   endtask

   task automatic send_element(input int unsigned n);
      send_length(n);
      send_plain(CH_PERIOD);
      repeat (n) send_char();
   endtask

   task automatic send_instruction(input int unsigned n, input bit tiny, input bit open_end);
      int unsigned e;
      for (e = 0; e < n; e++) begin
         send_element(pick_length(tiny));
         if (e == n - 1 && !open_end) begin
            send_plain(CH_SEMICOLON);
         end else begin
            send_plain(CH_COMMA);
         end
      end
   endtask

   task automatic send_random_instruction();
      int unsigned cap;
      int unsigned n;
      cap = stim_cap();
      if (cap <= 16 && $urandom_range(9) == 0) begin
         n = cap;
      end else begin
         n = $urandom_range(1, (cap < 6) ? cap : 6);
      end
      send_instruction(n, n > 6, 1'b0);
   endtask

   initial begin
      logic [15:0] len_plan [0:5];
      logic [7:0]  el_plan [0:5];
      int          blk;
      int          block_start;
      int unsigned fault;
      int unsigned lim;
      logic [7:0]  b;
      len_plan = '{16'd8192, 16'd0, 16'd65535, 16'd5, 16'd300, 16'd1};
      el_plan = '{8'd128, 8'd1, 8'd128, 8'd3, 8'd12, 8'd128};
      opening_rows = '{
         '{8'h30, 1'b1, '{K_LENGTH, 8'h30, 1'b0, 7'd0, 16'd0, 7'd0}},
         '{8'h2E, 1'b1, '{K_LENGTH, 8'h2E, 1'b0, 7'd0, 16'd0, 7'd0}},
         '{8'h3B, 1'b1, '{K_INSTR_END, 8'h3B, 1'b0, 7'd0, 16'd0, 7'd0}},
         '{8'h2E, 1'b1, '{K_LENGTH, 8'h2E, 1'b0, 7'd0, 16'd0, 7'd0}},
         '{8'h2C, 1'b1, '{K_ELEM_END, 8'h2C, 1'b0, 7'd0, 16'd0, 7'd0}},
         '{8'h37, 1'b1, '{K_LENGTH, 8'h37, 1'b0, 7'd1, 16'd7, 7'd0}},
         '{8'h2E, 1'b1, '{K_LENGTH, 8'h2E, 1'b0, 7'd1, 16'd7, 7'd0}},
         '{8'h00, 1'b1, '{K_CONTENT, 8'h00, 1'b1, 7'd1, 16'd7, 7'd0}},
         '{8'hC3, 1'b0, '0},
         '{8'hA9, 1'b0, '0},
         '{8'hE2, 1'b0, '0},
         '{8'h82, 1'b0, '0},
         '{8'hAC, 1'b0, '0},
         '{8'hF0, 1'b0, '0},
         '{8'h9F, 1'b0, '0},
         '{8'h98, 1'b0, '0},
         '{8'h80, 1'b0, '0},
         '{8'h80, 1'b0, '0},
         '{8'hFF, 1'b0, '0},
         '{8'h7F, 1'b0, '0},
         '{8'h3B, 1'b1, '{K_INSTR_END, 8'h3B, 1'b0, 7'd1, 16'd7, 7'd1}}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty opcode, bare period, then every character size and odd lead bytes
      foreach (opening_rows[r]) send_byte(opening_rows[r].data, opening_rows[r].typed,
                                          opening_rows[r].res);

      for (blk = 0; blk < 6; blk++) begin
         if (blk != 0) begin
            wait_drained();
            set_limits(len_plan[blk], el_plan[blk]);
         end
         block_start = bytes_taken;
         // every element slot used once, so index and count reach their top
         if (blk == 2) send_instruction(stim_cap(), 1'b1, 1'b0);
         while (bytes_taken - block_start < ITEMS / 6) begin
            if ($urandom_range(15) == 0) wait_drained();
            send_random_instruction();
         end
      end

      // errors are sticky, so exactly one kind of fault closes the run
      wait_drained();
      fault = $urandom_range(3);
      if (fault == 0) begin
         set_limits(stim_max_len, 8'($urandom_range(1, 4)));
         send_random_instruction();
         send_instruction(stim_cap(), 1'b1, 1'b1);
         send_fault_byte(8'($urandom_range(255)));
      end else if (fault == 1) begin
         case ($urandom_range(2))
            0: lim = 0;
            1: lim = 65535;
            default: lim = $urandom_range(65535);
         endcase
         set_limits(16'(lim), 8'd128);
         send_random_instruction();
         send_length(lim);
         send_fault_byte(CH_ZERO + 8'($urandom_range(1, 9)));
      end else if (fault == 2) begin
         send_random_instruction();
         send_length(pick_length(1'b0));
         do b = 8'($urandom_range(255)); while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_PERIOD);
         send_fault_byte(b);
      end else begin
         send_random_instruction();
         send_element(pick_length(1'b0));
         do b = 8'($urandom_range(255)); while (b == CH_COMMA || b == CH_SEMICOLON);
         send_fault_byte(b);
      end
      repeat (30) send_fault_byte(8'($urandom_range(255)));

      wait_drained();
      repeat (4) @(posedge clock);
      if (bad_classes == 0 && byte_classes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/lpip_pkg.sv
rtl/length_prefixed_instruction_parser.sv
rtl/lpip_checker.sv
verif/length_prefixed_instruction_parser_tb.sv
